// ----- rtl/core/lsvs_pkg.sv -----
// ----------------------------------------------------------------------------
// lsvs_pkg
// Shared types, sizes and helpers for the LIFO stack with value search.
// ----------------------------------------------------------------------------
package lsvs_pkg;

    localparam int unsigned DEPTH   = 16;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned OCC_W   = 5;
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_SEARCH = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle shift command shared by all cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [OCC_W-1:0] t_occ;

    // count or position onto the 5-bit result fields
    function automatic t_occ to_occ(input t_cnt c);
        return OCC_W'(c);
    endfunction

endpackage

// ----- rtl/core/lsvs_if.sv -----
// ----------------------------------------------------------------------------
// lsvs_if
// Valid/ready channels for operations in and results out.
// ----------------------------------------------------------------------------
interface lsvs_in_if;
    logic                               valid;
    logic                               ready;
    logic [lsvs_pkg::FUNC_W-1:0]        func;
    logic signed [lsvs_pkg::DATA_W-1:0] value_in;

    modport source (output valid, output func, output value_in, input ready);
    modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface lsvs_out_if;
    logic                               valid;
    logic                               ready;
    logic [lsvs_pkg::STAT_W-1:0]        status;
    logic [lsvs_pkg::OCC_W-1:0]         position;
    logic signed [lsvs_pkg::DATA_W-1:0] value_out;
    logic [lsvs_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output position, output value_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input position, input value_out,
                    input occupancy, output ready);
endinterface

// ----- rtl/core/lifo_stack_with_value_search.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_with_value_search
// Bounded LIFO of signed 32-bit values built as a shifting chain of cells,
// with a per-cell comparator for a topmost-match search.
//
//   channel | dir | beat payload
//   --------+-----+--------------------------------------------
//   i_in    | in  | func, value_in
//   o_out   | out | status, position, value_out, occupancy
//
// One beat in gives one beat out in the cycle after, from the result register.
// Push, pop and search each complete in the cell chain as the beat is taken, so a new
// beat is taken every cycle while the result register is empty or drained.
// A stalled result holds the input off; the chain itself never stalls.
// Reset clears the count and the result valid flag; cell contents stay as-is.
// ----------------------------------------------------------------------------
module lifo_stack_with_value_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsvs_in_if.sink       i_in,
    lsvs_out_if.source    o_out
);

    localparam int unsigned DEPTH = lsvs_pkg::DEPTH;

    lsvs_pkg::t_cnt              r_count;
    lsvs_pkg::t_cnt              n_count;
    lsvs_pkg::t_cell_ctrl        w_ctrl;
    lsvs_pkg::t_func             w_func;
    logic [lsvs_pkg::DATA_W-1:0] w_data  [DEPTH];
    logic [DEPTH-1:0]            w_match;
    logic [DEPTH-1:0]            w_occ;
    logic                        w_acc;
    logic                        w_full;
    logic                        w_empty;
    lsvs_pkg::t_cnt              w_hit;

    logic                        r_out_valid;
    lsvs_pkg::t_status           r_status;
    lsvs_pkg::t_status           n_status;
    lsvs_pkg::t_occ              r_pos;
    lsvs_pkg::t_occ              n_pos;
    logic [lsvs_pkg::DATA_W-1:0] r_vout;
    logic [lsvs_pkg::DATA_W-1:0] n_vout;
    lsvs_pkg::t_occ              r_occ;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_func     = lsvs_pkg::t_func'(i_in.func);
    assign w_full     = (r_count == lsvs_pkg::CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // cell chain, index 0 is the top of the stack
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [lsvs_pkg::DATA_W-1:0] w_above;
            logic [lsvs_pkg::DATA_W-1:0] w_below;

            if (g == 0) begin : g_top
                assign w_above = i_in.value_in;
            end else begin : g_mid
                assign w_above = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_bot
                assign w_below = w_data[g];
            end else begin : g_nbot
                assign w_below = w_data[g+1];
            end

            assign w_occ[g] = (lsvs_pkg::CNT_W'(g) < r_count);

            lsvs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .i_occ        (w_occ[g]),
                .i_key        (i_in.value_in),
                .o_data       (w_data[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    // topmost match wins: scan from bottom so the lowest index lands last
    always_comb begin
        w_hit = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit = lsvs_pkg::CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_status = lsvs_pkg::ST_OK;
        n_pos    = '0;
        n_vout   = '0;
        unique case (w_func)
            lsvs_pkg::FN_PUSH: begin
                if (w_full) begin
                    n_status = lsvs_pkg::ST_FULL;
                end else begin
                    w_ctrl.push = w_acc;
                    n_count     = r_count + 1'b1;
                end
            end
            lsvs_pkg::FN_POP: begin
                if (w_empty) begin
                    n_status = lsvs_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.pop = w_acc;
                    n_count    = r_count - 1'b1;
                    n_vout     = w_data[0];
                end
            end
            lsvs_pkg::FN_SEARCH: begin
                n_pos = lsvs_pkg::to_occ(w_hit);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_vout   <= n_vout;
            r_occ    <= lsvs_pkg::to_occ(n_count);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.position  = r_pos;
    assign o_out.value_out = r_vout;
    assign o_out.occupancy = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lsvs_pkg::CNT_W'(DEPTH))
        else $error("stack count beyond depth");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_func == lsvs_pkg::FN_PUSH && !w_full)
        |=> (w_data[0] == $past(i_in.value_in)) && (r_count == $past(r_count) + 1'b1))
        else $error("pushed value not on top");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == lsvs_pkg::ST_EMPTY)
        |-> (r_vout == '0) && (r_occ == '0))
        else $error("empty pop reported data or entries");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pos != '0) |-> (r_pos <= r_occ))
        else $error("search position beyond occupancy");

endmodule

// ----- rtl/core/lsvs_cell.sv -----
// ----------------------------------------------------------------------------
// lsvs_cell
// One stack slot: shifts down on push, up on pop, compares against the key.
// ----------------------------------------------------------------------------
module lsvs_cell (
    input  logic                        i_clk,
    input  lsvs_pkg::t_cell_ctrl        i_ctrl,
    input  logic [lsvs_pkg::DATA_W-1:0] i_from_above,
    input  logic [lsvs_pkg::DATA_W-1:0] i_from_below,
    input  logic                        i_occ,
    input  logic [lsvs_pkg::DATA_W-1:0] i_key,
    output logic [lsvs_pkg::DATA_W-1:0] o_data,
    output logic                        o_match
);

    logic [lsvs_pkg::DATA_W-1:0] r_data;
    logic [lsvs_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.push) begin
            n_data = i_from_above;
        end else if (i_ctrl.pop) begin
            n_data = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_occ && (r_data == i_key);

endmodule
